### hw/rtl/dsps_pkg.sv
package dsps_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned OFFSET_BITS   = 16;
  localparam int unsigned COUNT_BITS    = 8;
  localparam int unsigned DASH_BITS     = 16;

  localparam logic [7:0] BYTE_LEAD   = 8'hE2;
  localparam logic [7:0] BYTE_MID    = 8'h80;
  localparam logic [7:0] BYTE_EN     = 8'h93;
  localparam logic [7:0] BYTE_EM     = 8'h94;
  localparam logic [7:0] BYTE_HYPHEN = 8'h2D;

  localparam logic [COUNT_BITS-1:0] MAX_PARTS_RESET = COUNT_BITS'(16);

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_LEAD,
    MS_LEAD_MID,
    MS_HYPHEN,
    MS_HYPHEN_RUN
  } match_state_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic                   part_valid;
    logic [OFFSET_BITS-1:0] part_start;
    logic [OFFSET_BITS-1:0] part_end;
    logic [COUNT_BITS-1:0]  part_index;
    logic                   token_done;
    logic [COUNT_BITS-1:0]  part_total;
    logic [DASH_BITS-1:0]   dash_total;
  } out_req_t;

  function automatic match_state_e fresh_state(input logic [7:0] b);
    match_state_e s;
    if (b == BYTE_LEAD) begin
      s = MS_LEAD;
    end else if (b == BYTE_HYPHEN) begin
      s = MS_HYPHEN;
    end else begin
      s = MS_IDLE;
    end
    return s;
  endfunction

endpackage

### hw/rtl/dsps_match.sv
module dsps_match (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dsps_pkg::COUNT_BITS-1:0]      cfg_wdata_i,
  input  logic                                 accept_i,
  input  dsps_pkg::in_req_t                    req_i,
  output logic                                 res_valid_o,
  output dsps_pkg::out_req_t                   res_o
);

  localparam int unsigned PW = dsps_pkg::POSITION_BITS;
  localparam int unsigned CW = dsps_pkg::COUNT_BITS;
  localparam int unsigned DW = dsps_pkg::DASH_BITS;
  localparam int unsigned OW = dsps_pkg::OFFSET_BITS;

  logic [CW-1:0]          max_parts_q;
  dsps_pkg::pos_t         pos_q, pos_d;
  dsps_pkg::pos_t         start_q, start_d;
  dsps_pkg::match_state_e state_q, state_d;
  logic [CW-1:0]          parts_q, parts_d;
  logic [DW-1:0]          dashes_q, dashes_d;

  dsps_pkg::pos_t pos_next;
  dsps_pkg::pos_t sep_end;
  logic           sep_hit;
  logic           run_extend;
  logic           room;
  logic           sep_emit;
  logic           last_emit;
  logic [7:0]     b;

  assign b        = req_i.byte_value;
  assign pos_next = (pos_q == {PW{1'b1}}) ? pos_q : pos_q + PW'(1);
  assign room     = parts_q < max_parts_q;

  always_comb begin
    state_d    = state_q;
    sep_hit    = 1'b0;
    run_extend = 1'b0;
    sep_end    = '0;
    unique case (state_q)
      dsps_pkg::MS_LEAD: begin
        state_d = (b == dsps_pkg::BYTE_MID) ? dsps_pkg::MS_LEAD_MID
                                            : dsps_pkg::fresh_state(b);
      end
      dsps_pkg::MS_LEAD_MID: begin
        if (b == dsps_pkg::BYTE_EN || b == dsps_pkg::BYTE_EM) begin
          sep_hit = 1'b1;
          sep_end = (pos_q >= PW'(2)) ? pos_q - PW'(2) : '0;
          state_d = dsps_pkg::MS_IDLE;
        end else begin
          state_d = dsps_pkg::fresh_state(b);
        end
      end
      dsps_pkg::MS_HYPHEN: begin
        if (b == dsps_pkg::BYTE_HYPHEN) begin
          sep_hit = 1'b1;
          sep_end = (pos_q >= PW'(1)) ? pos_q - PW'(1) : '0;
          state_d = dsps_pkg::MS_HYPHEN_RUN;
        end else begin
          state_d = dsps_pkg::fresh_state(b);
        end
      end
      dsps_pkg::MS_HYPHEN_RUN: begin
        if (b == dsps_pkg::BYTE_HYPHEN) begin
          run_extend = 1'b1;
        end else begin
          state_d = dsps_pkg::fresh_state(b);
        end
      end
      default: begin
        state_d = dsps_pkg::fresh_state(b);
      end
    endcase
  end

  always_comb begin
    start_d   = (sep_hit || run_extend) ? pos_next : start_q;
    sep_emit  = sep_hit && (sep_end > start_q) && room;
    last_emit = req_i.last_byte && !sep_emit && (pos_next > start_d) && room;
    parts_d   = parts_q + CW'(sep_emit || last_emit);
    dashes_d  = (sep_hit && dashes_q != {DW{1'b1}}) ? dashes_q + DW'(1) : dashes_q;
    pos_d     = pos_next;

    res_o = '0;
    if (sep_emit) begin
      res_o.part_valid = 1'b1;
      res_o.part_start = OW'(start_q);
      res_o.part_end   = OW'(sep_end);
      res_o.part_index = parts_q;
    end else if (last_emit) begin
      res_o.part_valid = 1'b1;
      res_o.part_start = OW'(start_d);
      res_o.part_end   = OW'(pos_next);
      res_o.part_index = parts_q;
    end
    if (req_i.last_byte) begin
      res_o.token_done = 1'b1;
      res_o.part_total = parts_d;
      res_o.dash_total = dashes_d;
    end
    res_valid_o = accept_i && (sep_emit || req_i.last_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_parts_q <= dsps_pkg::MAX_PARTS_RESET;
    end else if (cfg_we_i) begin
      max_parts_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      state_q  <= dsps_pkg::MS_IDLE;
      parts_q  <= '0;
      dashes_q <= '0;
    end else if (accept_i) begin
      if (req_i.last_byte) begin
        pos_q    <= '0;
        start_q  <= '0;
        state_q  <= dsps_pkg::MS_IDLE;
        parts_q  <= '0;
        dashes_q <= '0;
      end else begin
        pos_q    <= pos_d;
        start_q  <= start_d;
        state_q  <= state_d;
        parts_q  <= parts_d;
        dashes_q <= dashes_d;
      end
    end
  end

endmodule

### hw/rtl/dsps_out_reg.sv
module dsps_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dsps_pkg::out_req_t data_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dsps_pkg::out_req_t out_req_o
);

  logic               valid_q, valid_d;
  dsps_pkg::out_req_t data_q;

  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_req_o   = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

### hw/rtl/dash_separated_part_splitter_core.sv
// Splits one UTF-8 word token into parts at dash separators.
// Bytes arrive on the input channel one request per cycle when not stalled,
// with last_byte set on the final byte of the token. En and em dashes and
// runs of two or more hyphens separate parts; a lone hyphen does not.
// A part is reported on the byte that completes the separator after it, and
// the closing part on the last byte, whose result also carries the part and
// dash totals. Bytes that complete nothing produce no result.
// A result is registered and output in the cycle after its byte is taken.
// The block takes one byte every cycle as long as the output register is
// free or being drained in the same cycle; the single output register sets
// that limit.
// When the receiver stalls with a result pending, the input is stalled too
// and the pending result holds steady.
// The max_parts register is written via cfg_we_i and cfg_wdata_i, by the
// user only while the block is idle, which the block does not enforce. Reset
// clears all token state, empties the output register and sets max_parts to 16.
module dash_separated_part_splitter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dsps_pkg::COUNT_BITS-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dsps_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dsps_pkg::out_req_t               out_req_o
);

  logic               accept;
  logic               res_valid;
  logic               busy;
  dsps_pkg::out_req_t res;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  dsps_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dsps_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .data_i      (res),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

### test/dash_separated_part_splitter_core_tb.sv
module dash_separated_part_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [dsps_pkg::COUNT_BITS-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  dsps_pkg::in_req_t               in_req_i    = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  dsps_pkg::out_req_t              out_req_o;

  dash_separated_part_splitter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  dsps_pkg::in_req_t  pending_bytes[$];
  dsps_pkg::out_req_t expected_parts[$];
  logic [7:0]         token_bytes[$];
  int                 bytes_pushed   = 0;
  int                 bytes_accepted = 0;
  int                 tokens_sent    = 0;
  int                 results_seen   = 0;
  int                 mismatches     = 0;
  int                 send_idle_pct  = 0;
  int                 stall_pct      = 0;
  logic               byte_taken     = 1'b0;

  logic [dsps_pkg::COUNT_BITS-1:0] max_parts_q = dsps_pkg::MAX_PARTS_RESET;
  dsps_pkg::pos_t                  byte_pos    = '0;
  dsps_pkg::pos_t                  part_from   = '0;
  dsps_pkg::match_state_e          match_q     = dsps_pkg::MS_IDLE;
  logic [dsps_pkg::COUNT_BITS-1:0] parts_out   = '0;
  logic [dsps_pkg::DASH_BITS-1:0]  dash_count  = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic dsps_pkg::match_state_e match_from_byte(input logic [7:0] b);
    if (b == dsps_pkg::BYTE_LEAD) begin
      return dsps_pkg::MS_LEAD;
    end
    if (b == dsps_pkg::BYTE_HYPHEN) begin
      return dsps_pkg::MS_HYPHEN;
    end
    return dsps_pkg::MS_IDLE;
  endfunction

  function automatic bit report_part(input dsps_pkg::pos_t from, input dsps_pkg::pos_t upto,
                                     inout dsps_pkg::out_req_t res);
    if (upto <= from || parts_out >= max_parts_q) begin
      return 1'b0;
    end
    res.part_valid = 1'b1;
    res.part_start = dsps_pkg::OFFSET_BITS'(from);
    res.part_end   = dsps_pkg::OFFSET_BITS'(upto);
    res.part_index = parts_out;
    parts_out++;
    return 1'b1;
  endfunction

  function automatic void split_byte(input dsps_pkg::in_req_t req);
    dsps_pkg::pos_t     here;
    dsps_pkg::pos_t     after;
    dsps_pkg::out_req_t res;
    bit                 got;
    here  = byte_pos;
    after = (byte_pos == '1) ? byte_pos : byte_pos + dsps_pkg::pos_t'(1);
    res   = '0;
    got   = 1'b0;
    case (match_q)
      dsps_pkg::MS_LEAD: begin
        match_q = (req.byte_value == dsps_pkg::BYTE_MID) ? dsps_pkg::MS_LEAD_MID
                                                         : match_from_byte(req.byte_value);
      end
      dsps_pkg::MS_LEAD_MID: begin
        if (req.byte_value == dsps_pkg::BYTE_EN || req.byte_value == dsps_pkg::BYTE_EM) begin
          got = report_part(part_from,
                            (here >= 2) ? here - dsps_pkg::pos_t'(2) : dsps_pkg::pos_t'(0),
                            res);
          part_from = after;
          if (dash_count != '1) dash_count++;
          match_q = dsps_pkg::MS_IDLE;
        end else begin
          match_q = match_from_byte(req.byte_value);
        end
      end
      dsps_pkg::MS_HYPHEN: begin
        if (req.byte_value == dsps_pkg::BYTE_HYPHEN) begin
          got = report_part(part_from,
                            (here >= 1) ? here - dsps_pkg::pos_t'(1) : dsps_pkg::pos_t'(0),
                            res);
          part_from = after;
          if (dash_count != '1) dash_count++;
          match_q = dsps_pkg::MS_HYPHEN_RUN;
        end else begin
          match_q = match_from_byte(req.byte_value);
        end
      end
      dsps_pkg::MS_HYPHEN_RUN: begin
        if (req.byte_value == dsps_pkg::BYTE_HYPHEN) begin
          part_from = after;
        end else begin
          match_q = match_from_byte(req.byte_value);
        end
      end
      default: begin
        match_q = match_from_byte(req.byte_value);
      end
    endcase
    byte_pos = after;
    if (req.last_byte) begin
      if (!got) void'(report_part(part_from, after, res));
      res.token_done = 1'b1;
      res.part_total = parts_out;
      res.dash_total = dash_count;
      byte_pos   = '0;
      part_from  = '0;
      match_q    = dsps_pkg::MS_IDLE;
      parts_out  = '0;
      dash_count = '0;
    end
    if (req.last_byte || got) expected_parts.push_back(res);
  endfunction

  function automatic void check_result(input dsps_pkg::out_req_t got);
    dsps_pkg::out_req_t exp;
    results_seen++;
    if (expected_parts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result at %0t: valid=%0d start=%0d end=%0d index=%0d done=%0d",
                 $realtime, got.part_valid, got.part_start, got.part_end, got.part_index,
                 got.token_done);
      end
      return;
    end
    exp = expected_parts.pop_front();
    if (got.part_valid !== exp.part_valid || got.part_start !== exp.part_start ||
        got.part_end !== exp.part_end || got.part_index !== exp.part_index ||
        got.token_done !== exp.token_done || got.part_total !== exp.part_total ||
        got.dash_total !== exp.dash_total) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch at %0t (valid start end index done parts dashes)", $realtime);
        $display("  expected %0d %0d %0d %0d %0d %0d %0d", exp.part_valid, exp.part_start,
                 exp.part_end, exp.part_index, exp.token_done, exp.part_total, exp.dash_total);
        $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got.part_valid, got.part_start,
                 got.part_end, got.part_index, got.token_done, got.part_total, got.dash_total);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(out_req_o);
      if (in_valid_i && !in_stall_o) begin
        split_byte(in_req_i);
        bytes_accepted++;
      end
      byte_taken <= in_valid_i && !in_stall_o;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic wait_drained();
    while (!(bytes_accepted == bytes_pushed && expected_parts.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_parts(input logic [dsps_pkg::COUNT_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    max_parts_q = value;
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic last);
    dsps_pkg::in_req_t req;
    req.byte_value = b;
    req.last_byte  = last;
    pending_bytes.push_back(req);
    bytes_pushed++;
  endfunction

  // A nonzero hold_at stops the sender after that many bytes until the block drains.
  task automatic queue_token(input int hold_at);
    for (int i = 0; i < token_bytes.size(); i++) begin
      push_byte(token_bytes[i], i == token_bytes.size() - 1);
      if (i + 1 == hold_at) wait_drained();
    end
    tokens_sent++;
  endtask

  function automatic void add_piece();
    case ($urandom_range(9))
      0, 1: token_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      2: token_bytes.push_back(8'($urandom_range(255)));
      3: token_bytes.push_back(dsps_pkg::BYTE_HYPHEN);
      4: repeat (2) token_bytes.push_back(dsps_pkg::BYTE_HYPHEN);
      5: repeat ($urandom_range(3, 6)) token_bytes.push_back(dsps_pkg::BYTE_HYPHEN);
      6, 7: begin
        token_bytes.push_back(dsps_pkg::BYTE_LEAD);
        token_bytes.push_back(dsps_pkg::BYTE_MID);
        token_bytes.push_back($urandom_range(1) ? dsps_pkg::BYTE_EN : dsps_pkg::BYTE_EM);
      end
      8: begin
        token_bytes.push_back(dsps_pkg::BYTE_LEAD);
        if ($urandom_range(1)) token_bytes.push_back(dsps_pkg::BYTE_MID);
      end
      default: begin
        token_bytes.push_back(dsps_pkg::BYTE_LEAD);
        token_bytes.push_back(dsps_pkg::BYTE_MID);
        token_bytes.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  function automatic void build_token();
    int pieces;
    token_bytes.delete();
    pieces = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    repeat (pieces) add_piece();
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct = 75; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 75; end
      3: begin send_idle_pct = 31; stall_pct = 31; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  initial begin
    logic [dsps_pkg::COUNT_BITS-1:0] phase_limits[8];
    int                              phase_start;
    phase_limits = '{8'd0, 8'd255, 8'd1, 8'd2, 8'($urandom_range(255)), 8'd3, 8'd16,
                     8'($urandom_range(255))};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    set_idling(0);
    token_bytes = '{8'hFF};
    queue_token(0);
    token_bytes = '{8'h00};
    queue_token(0);
    token_bytes = '{dsps_pkg::BYTE_HYPHEN};
    queue_token(0);
    token_bytes = '{dsps_pkg::BYTE_HYPHEN, dsps_pkg::BYTE_HYPHEN};
    queue_token(0);
    token_bytes = '{8'h61, dsps_pkg::BYTE_LEAD, dsps_pkg::BYTE_MID, dsps_pkg::BYTE_EN, 8'h62};
    queue_token(0);
    token_bytes = '{8'h61, dsps_pkg::BYTE_LEAD, dsps_pkg::BYTE_MID, dsps_pkg::BYTE_EM};
    queue_token(0);
    token_bytes = '{8'h61, dsps_pkg::BYTE_LEAD, dsps_pkg::BYTE_MID};
    queue_token(0);
    token_bytes = '{dsps_pkg::BYTE_LEAD, dsps_pkg::BYTE_LEAD, dsps_pkg::BYTE_MID,
                    dsps_pkg::BYTE_EN};
    queue_token(0);
    token_bytes = '{8'h78, dsps_pkg::BYTE_HYPHEN, dsps_pkg::BYTE_HYPHEN, dsps_pkg::BYTE_HYPHEN,
                    8'h79, dsps_pkg::BYTE_HYPHEN, 8'h7A};
    queue_token(0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_max_parts(phase_limits[phase]);
      set_idling(phase % 4);
      phase_start = bytes_pushed;
      if (phase == 0) begin
        do build_token(); while (token_bytes.size() < 4);
        queue_token(token_bytes.size() / 2);
      end
      while (bytes_pushed - phase_start < 75) begin
        build_token();
        queue_token(0);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes in %0d tokens across four idling patterns and eight part limits",
             bytes_pushed, tokens_sent);
    $display("with a drain in the middle of a token; %0d results checked, %0d bad",
             results_seen, mismatches);
    if (mismatches == 0 && expected_parts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dsps_pkg.sv
hw/rtl/dsps_match.sv
hw/rtl/dsps_out_reg.sv
hw/rtl/dash_separated_part_splitter_core.sv
test/dash_separated_part_splitter_core_tb.sv
